// ----- hw/rtl/pafi_pkg.sv -----
// ----------------------------------------------------------------------------
// pafi_pkg
// Shared codes, widths and types of the arm-then-fire power interlock.
// ----------------------------------------------------------------------------
package pafi_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CMD_W  = 8;

    localparam logic [TIME_W-1:0] ARM_WINDOW_RESET = 32'd5000;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ARMED = 2'd1;
    localparam logic [1:0] MODE_ON    = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_OFF     = 3'd1;
    localparam logic [2:0] EV_REJECT  = 3'd2;
    localparam logic [2:0] EV_STATUS  = 3'd3;
    localparam logic [2:0] EV_ARMED   = 3'd4;
    localparam logic [2:0] EV_ON      = 3'd5;
    localparam logic [2:0] EV_TIMEOUT = 3'd6;

    localparam logic [2:0] RS_NONE     = 3'd0;
    localparam logic [2:0] RS_TIMEOUT  = 3'd1;
    localparam logic [2:0] RS_POWERED  = 3'd2;
    localparam logic [2:0] RS_ARMFIRST = 3'd3;
    localparam logic [2:0] RS_UNKNOWN  = 3'd4;

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CMD_W-1:0] CH_X     = 8'h58;
    localparam logic [CMD_W-1:0] CH_A     = 8'h41;
    localparam logic [CMD_W-1:0] CH_P     = 8'h50;
    localparam logic [CMD_W-1:0] CH_S     = 8'h53;
    localparam logic [CMD_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CMD_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CMD_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CMD_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CMD_W-1:0] CASE_OFS = 8'h20;

    localparam logic REG_ARM_WINDOW = 1'b0;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       drive_level;
        logic       drive_en;
        logic [2:0] reason;
        logic [2:0] event_res;
    } result_t;

    typedef struct packed {
        logic              operation;
        logic [CMD_W-1:0]  command_byte;
        logic [TIME_W-1:0] now_ms;
    } item_t;

endpackage

// ----- hw/rtl/pafi_apb_regs.sv -----
// ----------------------------------------------------------------------------
// pafi_apb_regs
// APB register file holding the arm window.
// ----------------------------------------------------------------------------
module pafi_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [pafi_pkg::TIME_W-1:0]   arm_window_ms
);

    logic [pafi_pkg::TIME_W-1:0] window_reg;
    logic [pafi_pkg::TIME_W-1:0] window_next;

    assign pready = 1'b1;

    always_comb
    begin
        window_next = window_reg;
        if (psel && penable && pwrite && pready && paddr[2] == pafi_pkg::REG_ARM_WINDOW)
        begin
            window_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= pafi_pkg::ARM_WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    assign prdata        = (paddr[2] == pafi_pkg::REG_ARM_WINDOW) ? window_reg : 32'd0;
    assign arm_window_ms = window_reg;

endmodule

// ----- hw/rtl/pafi_step.sv -----
// ----------------------------------------------------------------------------
// pafi_step
// Interlock state and the one-pass decision for a single item.
// ----------------------------------------------------------------------------
module pafi_step
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  pafi_pkg::item_t               item,
    input  logic [pafi_pkg::TIME_W-1:0]   arm_window_ms,
    output pafi_pkg::result_t             result
);

    logic [1:0]                  mode_reg;
    logic [1:0]                  mode_next;
    logic [pafi_pkg::TIME_W-1:0] armed_time_reg;
    logic [pafi_pkg::TIME_W-1:0] armed_time_next;

    logic [pafi_pkg::CMD_W-1:0]  cmd;
    logic [pafi_pkg::TIME_W-1:0] age;
    logic                        lapsed;
    logic [1:0]                  mode_eff;
    logic [1:0]                  mode_calc;
    logic [pafi_pkg::TIME_W-1:0] armed_calc;

    assign age    = item.now_ms - armed_time_reg;
    assign lapsed = (mode_reg == pafi_pkg::MODE_ARMED) && (age >= arm_window_ms);

    always_comb
    begin
        cmd = item.command_byte;
        if (cmd >= pafi_pkg::CH_LOW_A && cmd <= pafi_pkg::CH_LOW_Z)
        begin
            cmd = cmd - pafi_pkg::CASE_OFS;
        end
    end

    always_comb
    begin
        result            = '0;
        result.event_res  = pafi_pkg::EV_NONE;
        result.reason     = pafi_pkg::RS_NONE;
        armed_calc        = armed_time_reg;
        mode_eff          = lapsed ? pafi_pkg::MODE_OFF : mode_reg;
        mode_calc         = mode_eff;
        if (item.operation == pafi_pkg::OP_TICK)
        begin
            if (lapsed)
            begin
                result.event_res = pafi_pkg::EV_TIMEOUT;
            end
        end
        else if (cmd == pafi_pkg::CH_X)
        begin
            mode_calc         = pafi_pkg::MODE_OFF;
            result.event_res  = pafi_pkg::EV_OFF;
            result.drive_en   = 1'b1;
        end
        else if (lapsed && cmd == pafi_pkg::CH_P)
        begin
            result.event_res = pafi_pkg::EV_REJECT;
            result.reason    = pafi_pkg::RS_TIMEOUT;
        end
        else if (cmd == pafi_pkg::CH_S)
        begin
            result.event_res = pafi_pkg::EV_STATUS;
        end
        else if (cmd == pafi_pkg::CH_A)
        begin
            if (mode_eff == pafi_pkg::MODE_ON)
            begin
                result.event_res = pafi_pkg::EV_REJECT;
                result.reason    = pafi_pkg::RS_POWERED;
            end
            else
            begin
                mode_calc        = pafi_pkg::MODE_ARMED;
                armed_calc       = item.now_ms;
                result.event_res = pafi_pkg::EV_ARMED;
            end
        end
        else if (cmd == pafi_pkg::CH_P)
        begin
            if (mode_eff != pafi_pkg::MODE_ARMED)
            begin
                result.event_res = pafi_pkg::EV_REJECT;
                result.reason    = (mode_eff == pafi_pkg::MODE_ON) ?
                                   pafi_pkg::RS_POWERED : pafi_pkg::RS_ARMFIRST;
            end
            else
            begin
                mode_calc          = pafi_pkg::MODE_ON;
                result.event_res   = pafi_pkg::EV_ON;
                result.drive_en    = 1'b1;
                result.drive_level = 1'b1;
            end
        end
        else if (cmd == pafi_pkg::CH_CR || cmd == pafi_pkg::CH_LF)
        begin
            result.event_res = pafi_pkg::EV_NONE;
        end
        else
        begin
            result.event_res = pafi_pkg::EV_REJECT;
            result.reason    = pafi_pkg::RS_UNKNOWN;
        end
        result.mode_now = mode_calc;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        armed_time_next = armed_time_reg;
        if (fire)
        begin
            mode_next       = mode_calc;
            armed_time_next = armed_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= pafi_pkg::MODE_OFF;
            armed_time_reg <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            armed_time_reg <= armed_time_next;
        end
    end

endmodule

// ----- hw/rtl/power_arm_fire_interlock.sv -----
// ----------------------------------------------------------------------------
// power_arm_fire_interlock
// Arm-then-fire power interlock: command bytes and time ticks in, one result
// item out per input item.
//
//   Channel  Dir  Handshake          Payload
//   s_axis   in   tvalid/tready      tdata: command_byte, now_ms; tuser: operation
//   m_axis   out  tvalid/tready      tdata: event_res .. mode_now
//   apb      in   psel/penable       arm_window_ms at byte address 0
//
// One item per cycle sustained while m_axis_tready is high; an accepted item
// passes through the input register and then the result register. The
// decision is one pass of logic between the input register and the result
// register; state updates as an item moves into the result register.
// Reset clears valid flags, mode and armed time and sets the window to 5000 ms.
// A stalled result holds the pipeline; s_axis_tready falls only when both
// registers are full and m_axis_tready is low.
// ----------------------------------------------------------------------------
module power_arm_fire_interlock
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] command_byte, [39:8] now_ms
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] event_res, [5:3] reason,
                                        // [6] drive_en, [7] drive_level,
                                        // [9:8] mode_now, [15:10] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    pafi_pkg::item_t             in_item_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    pafi_pkg::result_t           out_res_reg;
    pafi_pkg::result_t           step_res;
    logic [pafi_pkg::TIME_W-1:0] arm_window_ms;
    logic                        advance;
    logic                        take;

    pafi_apb_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .arm_window_ms (arm_window_ms)
    );

    pafi_step u_step
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .item          (in_item_reg),
        .arm_window_ms (arm_window_ms),
        .result        (step_res)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.operation    <= s_axis_tuser[0];
            in_item_reg.command_byte <= s_axis_tdata[7:0];
            in_item_reg.now_ms       <= s_axis_tdata[39:8];
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_res_reg};

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input register empty but not ready");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_res_reg.mode_now != 2'd3)
        else $error("illegal mode in result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((out_res_reg.reason != pafi_pkg::RS_NONE) ==
                           (out_res_reg.event_res == pafi_pkg::EV_REJECT)))
        else $error("reason does not match reject event");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.drive_en) |->
        (out_res_reg.event_res == pafi_pkg::EV_OFF ||
         out_res_reg.event_res == pafi_pkg::EV_ON))
        else $error("output driven on a non-switching event");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced item did not reach the result register");
`endif

endmodule

// ----- tb/power_arm_fire_interlock_tb.sv -----
// ----------------------------------------------------------------------------
// power_arm_fire_interlock_tb
// Self-checking bench for the arm-then-fire interlock. A queue-fed driver
// sends command and tick items with random gaps, and a monitor stalls results
// at random. Every result is checked field by field against an in-bench
// predictor of mode, arm time and window. The window is rewritten over APB
// between phases, including zero, one and the full 32-bit value.
// ----------------------------------------------------------------------------
module power_arm_fire_interlock_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pafi_pkg::*;

    localparam int unsigned   CYCLE_LIMIT     = 200000;
    localparam logic [2:0]    ADDR_ARM_WINDOW = {REG_ARM_WINDOW, 2'b00};

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // [7:0] command_byte, [39:8] now_ms
    logic [0:0]  s_axis_tuser  = '0;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;          // [2:0] event_res, [5:3] reason,
                                        // [6] drive_en, [7] drive_level,
                                        // [9:8] mode_now, [15:10] zero
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    item_t       pending_items[$];
    result_t     expected_results[$];

    logic [1:0]  pred_mode     = MODE_OFF;
    logic [31:0] pred_arm_time = '0;
    logic [31:0] pred_window   = ARM_WINDOW_RESET;

    logic [31:0] stim_now      = '0;
    logic [31:0] stim_arm_time = '0;
    logic [31:0] stim_window   = ARM_WINDOW_RESET;

    int unsigned send_gap      = 0;
    logic        send_burst    = 1'b0;
    int unsigned recv_stall    = 0;
    logic        recv_burst    = 1'b0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    power_arm_fire_interlock u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic result_t interlock_step(item_t it);
        result_t     r;
        logic [7:0]  ch;
        logic [31:0] age;
        logic        late;
        logic        done;
        r    = '0;
        age  = it.now_ms - pred_arm_time;
        late = (pred_mode == MODE_ARMED) && (age >= pred_window);
        done = 1'b0;
        if (it.operation == OP_TICK)
        begin
            if (late)
            begin
                pred_mode   = MODE_OFF;
                r.event_res = EV_TIMEOUT;
            end
        end
        else
        begin
            ch = it.command_byte;
            if (ch >= CH_LOW_A && ch <= CH_LOW_Z)
                ch = ch - CASE_OFS;
            if (ch == CH_X)
            begin
                pred_mode    = MODE_OFF;
                r.event_res  = EV_OFF;
                r.drive_en   = 1'b1;
                done         = 1'b1;
            end
            else if (late)
            begin
                pred_mode = MODE_OFF;
                if (ch == CH_P)
                begin
                    r.event_res = EV_REJECT;
                    r.reason    = RS_TIMEOUT;
                    done        = 1'b1;
                end
            end
            if (!done)
            begin
                if (ch == CH_S)
                    r.event_res = EV_STATUS;
                else if (ch == CH_A)
                begin
                    if (pred_mode == MODE_ON)
                    begin
                        r.event_res = EV_REJECT;
                        r.reason    = RS_POWERED;
                    end
                    else
                    begin
                        pred_mode     = MODE_ARMED;
                        pred_arm_time = it.now_ms;
                        r.event_res   = EV_ARMED;
                    end
                end
                else if (ch == CH_P)
                begin
                    if (pred_mode != MODE_ARMED)
                    begin
                        r.event_res = EV_REJECT;
                        r.reason    = (pred_mode == MODE_ON) ? RS_POWERED : RS_ARMFIRST;
                    end
                    else
                    begin
                        pred_mode     = MODE_ON;
                        r.event_res   = EV_ON;
                        r.drive_en    = 1'b1;
                        r.drive_level = 1'b1;
                    end
                end
                else if (ch == CH_CR || ch == CH_LF)
                    r.event_res = EV_NONE;
                else
                begin
                    r.event_res = EV_REJECT;
                    r.reason    = RS_UNKNOWN;
                end
            end
        end
        r.mode_now = pred_mode;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end
        else if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                s_axis_tdata  <= {it.now_ms, it.command_byte};
                s_axis_tuser  <= it.operation;
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_burst <= ~send_burst;
                send_gap <= send_burst ? 0 : $urandom_range(0, 9);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: check results first, then record the newly accepted item
    always @(posedge clk)
    begin
        result_t     got;
        result_t     want;
        item_t       it;
        int unsigned stall;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[9:0]);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(got.event_res));
                    check_field("reason", 32'(want.reason), 32'(got.reason));
                    check_field("drive_en", 32'(want.drive_en), 32'(got.drive_en));
                    check_field("drive_level", 32'(want.drive_level),
                                32'(got.drive_level));
                    check_field("mode_now", 32'(want.mode_now), 32'(got.mode_now));
                    check_field("tdata padding", 0, 32'(m_axis_tdata[15:10]));
                end
                if ($urandom_range(0, 31) == 0)
                    recv_burst <= ~recv_burst;
                stall = recv_burst ? 0 : $urandom_range(0, 9);
                recv_stall    <= stall;
                m_axis_tready <= (stall == 0);
            end
            else if (recv_stall != 0)
            begin
                recv_stall    <= recv_stall - 1;
                m_axis_tready <= (recv_stall == 1);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.operation    = s_axis_tuser[0];
                it.command_byte = s_axis_tdata[7:0];
                it.now_ms       = s_axis_tdata[39:8];
                expected_results.push_back(interlock_step(it));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_item(input logic op, input logic [7:0] cmd, input logic [31:0] now);
        item_t it;
        it.operation    = op;
        it.command_byte = cmd;
        it.now_ms       = now;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_window(input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ARM_WINDOW;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pred_window = value;
        stim_window = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_random(input int unsigned count);
        logic        op;
        logic [7:0]  cmd;
        int unsigned k;
        repeat (count)
        begin
            k = $urandom_range(0, 9);
            if (k < 5)
                stim_now = stim_now + $urandom_range(0, stim_window >> 2);
            else if (k < 8)
                stim_now = stim_arm_time + stim_window + 32'($urandom_range(0, 2)) - 32'd1;
            else if (k < 9)
                stim_now = stim_now + $urandom_range(0, 3);
            else
                stim_now = $urandom();
            op  = OP_CMD;
            cmd = 8'($urandom());
            k   = $urandom_range(0, 99);
            if (k < 15)
                op = OP_TICK;
            else if (k < 30)
                cmd = CH_A;
            else if (k < 40)
                cmd = CH_A | CASE_OFS;
            else if (k < 55)
                cmd = CH_P;
            else if (k < 65)
                cmd = CH_P | CASE_OFS;
            else if (k < 70)
                cmd = ($urandom_range(0, 1) != 0) ? CH_S : (CH_S | CASE_OFS);
            else if (k < 77)
                cmd = ($urandom_range(0, 1) != 0) ? CH_X : (CH_X | CASE_OFS);
            else if (k < 82)
                cmd = ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
            if (op == OP_CMD && (cmd == CH_A || cmd == (CH_A | CASE_OFS)))
                stim_arm_time = stim_now;
            add_item(op, cmd, stim_now);
        end
    endtask

    initial
    begin
        logic [31:0] windows[6];
        windows = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd100, 32'd0, 32'd2000};
        windows[4] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of 5000
        add_item(OP_TICK, 8'h00, 32'd0);
        add_item(OP_CMD, CH_S, 32'd0);
        add_item(OP_CMD, CH_P, 32'd10);
        add_item(OP_CMD, CH_A, 32'd100);
        add_item(OP_CMD, CH_A | CASE_OFS, 32'd200);
        add_item(OP_CMD, CH_P | CASE_OFS, 32'd300);
        add_item(OP_CMD, CH_A, 32'd400);
        add_item(OP_CMD, CH_P, 32'd500);
        add_item(OP_CMD, CH_S | CASE_OFS, 32'd600);
        add_item(OP_CMD, CH_CR, 32'd700);
        add_item(OP_CMD, CH_LF, 32'd800);
        add_item(OP_CMD, CH_X | CASE_OFS, 32'd900);
        add_item(OP_CMD, CH_A, 32'hFFFF_FF00);
        add_item(OP_TICK, 8'hFF, 32'h0000_1000);
        add_item(OP_TICK, 8'h00, 32'h0000_1288);
        add_item(OP_CMD, CH_A, 32'd1000);
        add_item(OP_CMD, CH_P, 32'd6000);
        add_item(OP_CMD, CH_A, 32'd1000);
        add_item(OP_CMD, CH_S, 32'd7000);
        add_item(OP_CMD, CH_A, 32'd0);
        add_item(OP_CMD, CH_A, 32'd9000);
        add_item(OP_CMD, CH_X, 32'd20000);
        add_item(OP_CMD, 8'hFF, 32'hFFFF_FFFF);
        add_item(OP_CMD, 8'h00, 32'd0);
        add_item(OP_CMD, CH_LOW_Z, 32'd1);
        add_item(OP_CMD, CH_LOW_Z + 8'd1, 32'd2);
        add_item(OP_CMD, CH_LOW_A - 8'd1, 32'd3);
        wait_idle();

        // zero window: an arm lapses at the next item
        write_window(32'd0);
        add_item(OP_CMD, CH_A, 32'd50);
        add_item(OP_CMD, CH_P, 32'd50);
        add_item(OP_CMD, CH_A, 32'd60);
        add_item(OP_TICK, 8'h00, 32'd60);
        wait_idle();

        foreach (windows[i])
        begin
            write_window(windows[i]);
            add_random(55);
            wait_idle();
            add_random(55);
            wait_idle();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- power_arm_fire_interlock.f -----
hw/rtl/pafi_pkg.sv
hw/rtl/pafi_apb_regs.sv
hw/rtl/pafi_step.sv
hw/rtl/power_arm_fire_interlock.sv
tb/power_arm_fire_interlock_tb.sv
